>>> rtl/stt_pkg.sv
// shared types and constants of the source text tokenizer
package stt_pkg;

  // scan modes of the front end
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_INT   = 3'd2,
    MODE_DOT   = 3'd3,
    MODE_FRAC  = 3'd4,
    MODE_OP    = 3'd5
  } mode_t;

  // token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_IDENT   = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_LPAREN  = 5'd3;
  localparam logic [4:0] KIND_RPAREN  = 5'd4;
  localparam logic [4:0] KIND_LBRACE  = 5'd5;
  localparam logic [4:0] KIND_RBRACE  = 5'd6;
  localparam logic [4:0] KIND_SEMI    = 5'd7;
  localparam logic [4:0] KIND_COMMA   = 5'd8;
  localparam logic [4:0] KIND_DOT     = 5'd9;
  localparam logic [4:0] KIND_MINUS   = 5'd10;
  localparam logic [4:0] KIND_PLUS    = 5'd11;
  localparam logic [4:0] KIND_SLASH   = 5'd12;
  localparam logic [4:0] KIND_STAR    = 5'd13;
  localparam logic [4:0] KIND_OP_BASE = 5'd14;
  localparam logic [4:0] KIND_ERROR   = 5'd22;

  // pending operator codes
  localparam logic [1:0] OP_BANG = 2'd0;
  localparam logic [1:0] OP_EQ   = 2'd1;
  localparam logic [1:0] OP_LT   = 2'd2;
  localparam logic [1:0] OP_GT   = 2'd3;

  // character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // token queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // one token as it leaves the block
  typedef struct packed {
    logic [15:0] length;
    logic [15:0] offset;
    logic [4:0]  kind;
  } tok_t;

  // all tokens caused by one input byte
  typedef struct packed {
    logic [1:0]     count;
    tok_t [2:0]     tok;
  } bundle_t;

  // queue status seen by the back end
  typedef struct packed {
    logic    empty;
    bundle_t head;
  } q_status_t;

endpackage

>>> rtl/source_text_tokenizer.sv
// top level of the streaming source text tokenizer
// Source bytes enter on the in_ stream, one byte per beat; byte value 0 ends
// the text. Tokens leave on the out_ stream, one token per beat, with tlast
// set on the final token caused by an input byte. Bytes that cause no token
// (whitespace, bytes inside an identifier or number) produce no output beat.
// A token is queued when the byte that ends it is accepted and shows on
// out_tvalid once its bundle heads the queue. Throughput: one byte per
// cycle while the queue is not full, set by the front end scan state
// update; a byte causes up to three tokens, sent one per beat.
// A four-entry bundle queue sits between the two sides, so input keeps
// flowing while results wait; in_tready drops only when the queue is full.
// When the receiver stalls, the head token holds on out_tdata until taken.
// Reset (synchronous, active low) returns the scanner to idle with all
// positions at zero and empties the queue; end of text does the same for
// the scan state after the eof token is queued.
module source_text_tokenizer import stt_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [4:0] token_kind, [20:5] token_offset,
                                  // [36:21] token_length, [39:37] zero
  output logic        out_tlast
);

  logic      push, pop, q_full;
  bundle_t   push_data;
  q_status_t q_status;

  // scanner
  stt_front #(
    .POS_BITS(POS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .text_byte (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  // bundle queue
  stt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .status    (q_status),
    .full      (q_full)
  );

  // token sender
  stt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .status     (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/stt_front.sv
// front end: byte classification, scan state and token bundle build
module stt_front import stt_pkg::*; #(
  parameter int POS_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    text_byte,
  input  logic          q_full,
  output logic          push,
  output bundle_t       push_data
);

  mode_t                mode_r, mode_nxt;
  logic [1:0]           pend_r, pend_nxt;
  logic [POS_BITS-1:0]  start_r, start_nxt;
  logic [POS_BITS-1:0]  cur_r, cur_nxt;
  logic [POS_BITS-1:0]  dot_r, dot_nxt;

  logic       is_nul, is_ws, is_digit, is_alpha, is_op;
  logic [1:0] op_code;
  logic [4:0] single_kind;
  logic       fresh;
  logic       accept;

  tok_t       ta, tb, tf;
  logic [1:0] nflush;
  logic       fresh_emit;
  logic [4:0] op_kind;

  // low 16 bits of a position
  function automatic logic [15:0] off16(input logic [POS_BITS-1:0] pos);
    logic [31:0] w;
    w = 32'(pos);
    return w[15:0];
  endfunction

  // distance saturated to 16 bits
  function automatic logic [15:0] sat16(input logic [POS_BITS-1:0] d);
    logic [31:0] w;
    w = 32'(d);
    return (|w[31:16]) ? 16'hFFFF : w[15:0];
  endfunction

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !q_full;

  // byte classes
  always_comb begin
    is_nul   = (text_byte == CH_NUL);
    is_ws    = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
               (text_byte == CH_CR) || (text_byte == CH_LF);
    is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    is_alpha = ((text_byte >= CH_LO_A) && (text_byte <= CH_LO_Z)) ||
               ((text_byte >= CH_UP_A) && (text_byte <= CH_UP_Z)) ||
               (text_byte == CH_UNDER);
    is_op   = 1'b1;
    op_code = OP_BANG;
    unique case (text_byte)
      CH_BANG: op_code = OP_BANG;
      CH_EQ:   op_code = OP_EQ;
      CH_LT:   op_code = OP_LT;
      CH_GT:   op_code = OP_GT;
      default: is_op = 1'b0;
    endcase
    single_kind = KIND_ERROR;
    unique case (text_byte)
      CH_LPAREN: single_kind = KIND_LPAREN;
      CH_RPAREN: single_kind = KIND_RPAREN;
      CH_LBRACE: single_kind = KIND_LBRACE;
      CH_RBRACE: single_kind = KIND_RBRACE;
      CH_SEMI:   single_kind = KIND_SEMI;
      CH_COMMA:  single_kind = KIND_COMMA;
      CH_DOT:    single_kind = KIND_DOT;
      CH_MINUS:  single_kind = KIND_MINUS;
      CH_PLUS:   single_kind = KIND_PLUS;
      CH_SLASH:  single_kind = KIND_SLASH;
      CH_STAR:   single_kind = KIND_STAR;
      default:   single_kind = KIND_ERROR;
    endcase
  end

  // next scan state
  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    start_nxt = start_r;
    dot_nxt   = dot_r;
    cur_nxt   = cur_r + POS_BITS'(1);
    fresh     = 1'b0;
    unique case (mode_r)
      MODE_IDENT: begin
        if (!(is_alpha || is_digit)) fresh = 1'b1;
      end
      MODE_INT: begin
        if (is_digit) begin
          mode_nxt = MODE_INT;
        end else if (text_byte == CH_DOT) begin
          mode_nxt = MODE_DOT;
          dot_nxt  = cur_r;
        end else begin
          fresh = 1'b1;
        end
      end
      MODE_DOT: begin
        if (is_digit) mode_nxt = MODE_FRAC;
        else fresh = 1'b1;
      end
      MODE_FRAC: begin
        if (!is_digit) fresh = 1'b1;
      end
      MODE_OP: begin
        if (text_byte == CH_EQ) mode_nxt = MODE_IDLE;
        else fresh = 1'b1;
      end
      default: fresh = 1'b1;
    endcase
    // start over on this byte
    if (fresh) begin
      mode_nxt = MODE_IDLE;
      if (is_nul) begin
        pend_nxt  = OP_BANG;
        start_nxt = '0;
        cur_nxt   = '0;
        dot_nxt   = '0;
      end else if (is_alpha) begin
        mode_nxt  = MODE_IDENT;
        start_nxt = cur_r;
      end else if (is_digit) begin
        mode_nxt  = MODE_INT;
        start_nxt = cur_r;
      end else if (is_op) begin
        mode_nxt  = MODE_OP;
        pend_nxt  = op_code;
        start_nxt = cur_r;
      end
    end
  end

  // tokens caused by this byte
  always_comb begin
    op_kind = KIND_OP_BASE + {2'b00, pend_r, 1'b0};
    ta      = '0;
    tb      = '0;
    nflush  = 2'd0;
    unique case (mode_r)
      MODE_IDENT: begin
        if (fresh) begin
          ta     = '{length: sat16(cur_r - start_r), offset: off16(start_r),
                     kind: KIND_IDENT};
          nflush = 2'd1;
        end
      end
      MODE_INT, MODE_FRAC: begin
        if (fresh) begin
          ta     = '{length: sat16(cur_r - start_r), offset: off16(start_r),
                     kind: KIND_NUMBER};
          nflush = 2'd1;
        end
      end
      MODE_DOT: begin
        if (fresh) begin
          ta     = '{length: sat16(dot_r - start_r), offset: off16(start_r),
                     kind: KIND_NUMBER};
          tb     = '{length: 16'd1, offset: off16(dot_r), kind: KIND_DOT};
          nflush = 2'd2;
        end
      end
      MODE_OP: begin
        if (text_byte == CH_EQ) begin
          ta = '{length: 16'd2, offset: off16(start_r), kind: op_kind + 5'd1};
        end else begin
          ta = '{length: 16'd1, offset: off16(start_r), kind: op_kind};
        end
        nflush = 2'd1;
      end
      default: nflush = 2'd0;
    endcase
    // eof, punctuation or error token from a fresh scan
    if (is_nul) begin
      tf = '{length: 16'd0, offset: off16(cur_r), kind: KIND_EOF};
    end else begin
      tf = '{length: 16'd1, offset: off16(cur_r), kind: single_kind};
    end
    fresh_emit = fresh && (is_nul || !(is_ws || is_alpha || is_digit || is_op));
    // pack flushed tokens first, fresh token after them
    push_data.tok = '{tf, tf, tf};
    case (nflush)
      2'd1: begin
        push_data.tok[0] = ta;
      end
      2'd2: begin
        push_data.tok[0] = ta;
        push_data.tok[1] = tb;
      end
      default: push_data.tok[0] = tf;
    endcase
    push_data.count = nflush + {1'b0, fresh_emit};
  end

  assign push = accept && (push_data.count != 2'd0);

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pend_r  <= OP_BANG;
      start_r <= '0;
      cur_r   <= '0;
      dot_r   <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      start_r <= start_nxt;
      cur_r   <= cur_nxt;
      dot_r   <= dot_nxt;
    end
  end

endmodule

>>> rtl/stt_queue.sv
// short bundle queue between front and back end
module stt_queue import stt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bundle_t   push_data,
  input  logic      pop,
  output q_status_t status,
  output logic      full
);

  bundle_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   cnt_r, cnt_nxt;

  assign full         = (cnt_r == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign status.head  = entry_r[rd_ptr_r];

  // fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> rtl/stt_back.sv
// back end: sends the tokens of each bundle one beat at a time
module stt_back import stt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_status_t   status,
  output logic        pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tlast
);

  logic [1:0] idx_r;
  tok_t       tok;
  logic       beat;

  assign out_tvalid = !status.empty;
  assign beat       = out_tvalid && out_tready;

  // token select and last flag
  always_comb begin
    case (idx_r)
      2'd1:    tok = status.head.tok[1];
      2'd2:    tok = status.head.tok[2];
      default: tok = status.head.tok[0];
    endcase
    out_tlast = (idx_r == (status.head.count - 2'd1));
  end

  assign out_tdata = {3'b000, tok.length, tok.offset, tok.kind};
  assign pop       = beat && out_tlast;

  // position within the head bundle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (beat) begin
      idx_r <= out_tlast ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
